// ----- rtl/frc_pkg.sv -----
package frc_pkg;

  localparam int ID_W    = 32;
  localparam int COUNT_W = 6;
  localparam int LIMIT_W = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;
    logic report_start;
    logic report_step;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic count_le_one;
    logic rem_last;
    logic store_empty;
  } dp_status_t;

endpackage

// ----- rtl/frc_req_if.sv -----
interface frc_req_if;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [frc_pkg::ID_W-1:0] id_value;

  modport source (output valid, output command, output id_value, input ready);
  modport sink (input valid, input command, input id_value, output ready);
endinterface

// ----- rtl/frc_rsp_if.sv -----
interface frc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [frc_pkg::ID_W-1:0]    entry_value;
  logic [frc_pkg::COUNT_W-1:0] entry_count;
  logic                        has_entry;
  logic                        last_of_run;

  modport source (output valid, output entry_value, output entry_count,
                  output has_entry, output last_of_run, input ready);
  modport sink (input valid, input entry_value, input entry_count,
                input has_entry, input last_of_run, output ready);
endinterface

// ----- rtl/frc_ctrl.sv -----
module frc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_command,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  frc_pkg::dp_status_t status,
  output frc_pkg::dp_cmd_t    cmd
);

  frc_pkg::state_t state;
  frc_pkg::state_t state_next;
  logic            out_valid_next;
  logic            out_free;
  logic            accept;

  assign out_free = !out_valid || out_ready;

  // Output decode.
  always_comb begin
    in_ready         = (state == frc_pkg::ST_IDLE) && out_free;
    accept           = in_valid && in_ready;
    cmd.insert       = accept && (in_command == frc_pkg::CMD_INSERT);
    cmd.report_start = accept && (in_command == frc_pkg::CMD_REPORT);
    cmd.report_step  = (state == frc_pkg::ST_DRAIN) && out_free;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      frc_pkg::ST_IDLE: begin
        if (cmd.report_start && !status.count_le_one) begin
          state_next = frc_pkg::ST_DRAIN;
        end
      end
      frc_pkg::ST_DRAIN: begin
        if (cmd.report_step && status.rem_last) begin
          state_next = frc_pkg::ST_IDLE;
        end
      end
      default: state_next = frc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.report_start || cmd.report_step) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= frc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/frc_datapath.sv -----
module frc_datapath #(
  parameter int CAPACITY = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [frc_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  logic [frc_pkg::ID_W-1:0]     id_value,
  input  frc_pkg::dp_cmd_t             cmd,
  output frc_pkg::dp_status_t          status,
  output logic [frc_pkg::ID_W-1:0]     entry_value,
  output logic [frc_pkg::COUNT_W-1:0]  entry_count,
  output logic                         has_entry,
  output logic                         last_of_run
);

  localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > frc_pkg::LIMIT_W) ? CNT_W : frc_pkg::LIMIT_W;
  localparam int SW    = PTR_W + 2;

  logic [frc_pkg::ID_W-1:0]    entries [CAPACITY];
  logic [PTR_W-1:0]            oldest;
  logic [CNT_W-1:0]            count;
  logic [frc_pkg::LIMIT_W-1:0] limit;
  logic [PTR_W-1:0]            rd_idx;
  logic [CNT_W-1:0]            rem;
  logic [frc_pkg::COUNT_W-1:0] run_count;

  logic [CAPACITY-1:0] hit_vec;
  logic                hit;
  logic                full;
  logic [CW-1:0]       lim_eff;
  logic [CNT_W-1:0]    count_after;
  logic                drop;
  logic                grow;
  logic                evict;
  logic [PTR_W-1:0]    oldest_inc;
  logic [PTR_W-1:0]    wr_slot;
  logic [PTR_W-1:0]    top_slot;
  logic [PTR_W-1:0]    rd_dec;
  logic [PTR_W-1:0]    top_dec;
  logic [SW-1:0]       sum_wr;
  logic [SW-1:0]       sum_top;

  // Associative lookup: an entry counts only if its offset from the oldest
  // slot lies below the held count.
  always_comb begin
    logic [SW-1:0] offset;
    for (int i = 0; i < CAPACITY; i++) begin
      if (SW'(i) >= SW'(oldest)) begin
        offset = SW'(i) - SW'(oldest);
      end else begin
        offset = SW'(i) + SW'(CAPACITY) - SW'(oldest);
      end
      hit_vec[i] = (offset < SW'(count)) && (entries[i] == id_value);
    end
  end

  assign hit  = |hit_vec;
  assign full = (count >= CNT_W'(CAPACITY));

  always_comb begin
    if (limit == '0) begin
      lim_eff = CW'(1);
    end else if (CW'(limit) > CW'(CAPACITY)) begin
      lim_eff = CW'(CAPACITY);
    end else begin
      lim_eff = CW'(limit);
    end
  end

  assign evict       = !hit && full;
  assign grow        = !hit && !full;
  assign count_after = count + CNT_W'(grow);
  assign drop        = !evict && (CW'(count_after) > lim_eff);

  assign oldest_inc = (oldest == PTR_W'(CAPACITY - 1)) ? '0 : oldest + PTR_W'(1);
  assign rd_dec     = (rd_idx == '0) ? PTR_W'(CAPACITY - 1) : rd_idx - PTR_W'(1);
  assign top_dec    = (top_slot == '0) ? PTR_W'(CAPACITY - 1) : top_slot - PTR_W'(1);

  // Slot of the next free entry and of the newest entry, both modulo CAPACITY.
  assign sum_wr  = SW'(oldest) + SW'(count);
  assign sum_top = SW'(oldest) + SW'(count) - SW'(1);
  assign wr_slot = (sum_wr >= SW'(CAPACITY)) ? PTR_W'(sum_wr - SW'(CAPACITY))
                                             : PTR_W'(sum_wr);
  assign top_slot = (sum_top >= SW'(CAPACITY)) ? PTR_W'(sum_top - SW'(CAPACITY))
                                               : PTR_W'(sum_top);

  always_comb begin
    status.count_le_one = (count <= CNT_W'(1));
    status.rem_last     = (rem == CNT_W'(1));
    status.store_empty  = (count == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && evict) begin
      entries[oldest] <= id_value;
    end else if (cmd.insert && grow) begin
      entries[wr_slot] <= id_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      count  <= '0;
      limit  <= frc_pkg::LIMIT_RESET;
      rem    <= '0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (cmd.insert) begin
        if (evict || drop) begin
          oldest <= oldest_inc;
        end
        count <= count_after - CNT_W'(drop);
      end else if (cmd.report_start) begin
        oldest <= '0;
        count  <= '0;
        rem    <= (count == '0) ? '0 : count - CNT_W'(1);
      end else if (cmd.report_step) begin
        rem <= rem - CNT_W'(1);
      end
    end
  end

  // Result register and drain pointer.
  always_ff @(posedge clk) begin
    if (cmd.report_start) begin
      run_count <= frc_pkg::COUNT_W'(count);
      rd_idx    <= top_dec;
      if (count == '0) begin
        entry_value <= '0;
        entry_count <= '0;
        has_entry   <= 1'b0;
        last_of_run <= 1'b1;
      end else begin
        entry_value <= entries[top_slot];
        entry_count <= frc_pkg::COUNT_W'(count);
        has_entry   <= 1'b1;
        last_of_run <= (count == CNT_W'(1));
      end
    end else if (cmd.report_step) begin
      rd_idx      <= rd_dec;
      entry_value <= entries[rd_idx];
      entry_count <= run_count;
      has_entry   <= 1'b1;
      last_of_run <= (rem == CNT_W'(1));
    end
  end

endmodule

// ----- rtl/fifo_replacement_id_cache_unit.sv -----
// Insert requests may follow back to back; they give no result.
// A report request with n held entries gives max(n,1) results, one per cycle while the
// consumer takes them, the first in the cycle after acceptance; requests wait meanwhile.
// The report rate is set by the single read of the entry array per cycle.
// Synchronous active-high reset empties the store and sets the entry limit to 32;
// entry contents are not cleared, since only held entries are ever read.
module fifo_replacement_id_cache_unit #(
  parameter int CAPACITY = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [frc_pkg::LIMIT_W-1:0] cfg_wdata,
  frc_req_if.sink                     request,
  frc_rsp_if.source                   result
);

  // The controller decides when a request is taken and when a result is
  // loaded; the datapath holds the entry array, the FIFO pointers and the
  // result register.
  frc_pkg::dp_cmd_t    cmd;
  frc_pkg::dp_status_t status;

  frc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (request.valid),
    .in_command (request.command),
    .in_ready   (request.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Inserts compare the id against every held entry in parallel and update
  // the oldest pointer and count in the same cycle. Reports walk from the
  // newest entry backward, one entry per result.
  frc_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .id_value    (request.id_value),
    .cmd         (cmd),
    .status      (status),
    .entry_value (result.entry_value),
    .entry_count (result.entry_count),
    .has_entry   (result.has_entry),
    .last_of_run (result.last_of_run)
  );

`ifndef SYNTH
  // A report request always produces a result in the next cycle.
  a_report_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.report_start |=> result.valid)
    else $error("report request did not produce a result");

  // A report leaves the store empty.
  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.report_start |=> status.store_empty)
    else $error("store not empty after report");

  // No new request is taken while a report is still draining.
  a_no_accept_in_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.report_step |-> !request.ready)
    else $error("request accepted during report drain");

  // The last result of a run is the only one that lets requests resume.
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.report_step && !status.rem_last) |=> !request.ready)
    else $error("report run ended early");
`endif

endmodule
